[rtl/core/ppsl_pkg.sv]
`default_nettype none
package ppsl_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int TIME_WIDTH_DEF = 48;
   localparam int PHASE_W        = 4;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_COMMIT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_OVF   = 3'd2;
   localparam logic [2:0] ST_NOREP = 3'd3;
   localparam logic [2:0] ST_ZERO  = 3'd4;

   localparam logic KIND_COMMIT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RKEY,
      S_GKEY,
      S_RJ,
      S_EJ,
      S_WR,
      S_TRD,
      S_TEV,
      S_CHK,
      S_QSTART,
      S_QMOD,
      S_QRD,
      S_QEV,
      S_EMIT
   } state_type;

endpackage
`default_nettype wire

[rtl/core/periodic_phase_schedule_lookup_unit.sv]
`default_nettype none
// Channel | dir | tdata (low bit up)                 | tuser
// req_    | in  | time_ticks, phase_code, zero fill  | op
// rsp_    | out | commit_status, found, phase_out    | kind
//
// Load: no result. Commit: rank sort over the n staged entries, then a trim
//   pass over the sorted bank and a check that the period closes.
// Query: serial remainder into the period, then a scan of the entries.
// Reset is synchronous and clears the state and counts; the tables are not cleared.
// A new result waits in S_EMIT while rsp_ is stalled; req_ is taken in idle only.
module periodic_phase_schedule_lookup_unit #(
   parameter int DEPTH      = ppsl_pkg::DEPTH_DEF,
   parameter int TIME_WIDTH = ppsl_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // time_ticks, phase_code, zero fill
   input  wire logic [((TIME_WIDTH+ppsl_pkg::PHASE_W+7)/8)*8-1:0] req_tdata,
   // op
   input  wire logic [1:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // commit_status, found, phase_out
   output logic      [7:0]                          rsp_tdata,
   // kind
   output logic      [0:0]                          rsp_tuser
);

   localparam int TW = TIME_WIDTH;
   localparam int PW = ppsl_pkg::PHASE_W;
   localparam int EW = TW + PW;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ppsl_pkg::state_type state_ff, state_in;

   // staging and schedule bookkeeping
   logic [CW-1:0] stage_count_ff, stage_count_in;
   logic          stage_ovf_ff, stage_ovf_in;
   logic [CW-1:0] act_count_ff, act_count_in;
   logic [TW-1:0] cycle_ff, cycle_in;
   logic [TW-1:0] act_t0_ff, act_t0_in;
   logic [PW-1:0] act_p0_ff, act_p0_in;
   logic          bank_ff, bank_in;

   // commit work registers
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [AW-1:0] rank_ff, rank_in;
   logic [TW-1:0] key_t_ff, key_t_in;
   logic [PW-1:0] key_p_ff, key_p_in;
   logic [TW-1:0] t0_ff, t0_in, prev_t_ff, prev_t_in, last_t_ff, last_t_in;
   logic [PW-1:0] p0_ff, p0_in, p1_ff, p1_in, prev_p_ff, prev_p_in;
   logic [PW-1:0] last_p_ff, last_p_in;
   logic [CW-1:0] last_ff, last_in;

   // query work registers
   logic [TW-1:0] qdiff_ff, qdiff_in;
   logic          neg_ff, neg_in;
   logic [TW-1:0] off_ff, off_in;

   // pending and presented result
   logic          res_kind_ff, res_kind_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic          res_found_ff, res_found_in;
   logic [PW-1:0] res_phase_ff, res_phase_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_kind_ff, rsp_kind_in;

   // memories
   logic          st_we;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [EW-1:0] st_rdata;
   logic          ac_we;
   logic [AW:0]   ac_waddr, ac_raddr;
   logic [EW-1:0] ac_rdata;

   logic          mod_start, mod_done;
   logic [TW-1:0] mod_rem;

   logic [TW-1:0] in_time;
   logic [PW-1:0] in_phase;
   logic [TW-1:0] st_t, ac_t;
   logic [PW-1:0] st_p, ac_p;
   logic          accept;

   assign in_time  = req_tdata[TW-1:0];
   assign in_phase = req_tdata[TW +: PW];
   assign st_t     = st_rdata[TW-1:0];
   assign st_p     = st_rdata[TW +: PW];
   assign ac_t     = ac_rdata[TW-1:0];
   assign ac_p     = ac_rdata[TW +: PW];
   assign accept   = req_tvalid && req_tready;

   ppsl_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_stage_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data ({in_phase, in_time}),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // two banks: the live schedule and the one being built
   ppsl_ram #(.WIDTH(EW), .DEPTH(2 * DEPTH)) u_active_ram (
      .clock   (clock),
      .wr_en   (ac_we),
      .wr_addr (ac_waddr),
      .wr_data ({key_p_ff, key_t_ff}),
      .rd_addr (ac_raddr),
      .rd_data (ac_rdata)
   );

   ppsl_mod #(.TIME_WIDTH(TW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (qdiff_ff),
      .divisor   (cycle_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in       = state_ff;
      stage_count_in = stage_count_ff;
      stage_ovf_in   = stage_ovf_ff;
      act_count_in   = act_count_ff;
      cycle_in       = cycle_ff;
      act_t0_in      = act_t0_ff;
      act_p0_in      = act_p0_ff;
      bank_in        = bank_ff;
      n_in           = n_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      rank_in        = rank_ff;
      key_t_in       = key_t_ff;
      key_p_in       = key_p_ff;
      t0_in          = t0_ff;
      p0_in          = p0_ff;
      p1_in          = p1_ff;
      prev_t_in      = prev_t_ff;
      prev_p_in      = prev_p_ff;
      last_t_in      = last_t_ff;
      last_p_in      = last_p_ff;
      last_in        = last_ff;
      qdiff_in       = qdiff_ff;
      neg_in         = neg_ff;
      off_in         = off_ff;
      res_kind_in    = res_kind_ff;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_phase_in   = res_phase_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_kind_in    = rsp_kind_ff;
      req_tready     = (state_ff == ppsl_pkg::S_IDLE);
      st_we          = 1'b0;
      st_waddr       = stage_count_ff[AW-1:0];
      st_raddr       = i_ff[AW-1:0];
      ac_we          = 1'b0;
      ac_waddr       = {~bank_ff, rank_ff};
      ac_raddr       = {~bank_ff, i_ff[AW-1:0]};
      mod_start      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ppsl_pkg::S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  ppsl_pkg::OP_LOAD: begin
                     if (stage_count_ff < CW'(DEPTH)) begin
                        st_we          = 1'b1;
                        stage_count_in = stage_count_ff + CW'(1);
                     end else begin
                        stage_ovf_in = 1'b1;
                     end
                  end
                  ppsl_pkg::OP_COMMIT: begin
                     stage_count_in = '0;
                     stage_ovf_in   = 1'b0;
                     res_kind_in    = ppsl_pkg::KIND_COMMIT;
                     res_found_in   = 1'b0;
                     res_phase_in   = '0;
                     n_in           = stage_count_ff;
                     i_in           = '0;
                     if (stage_count_ff == '0) begin
                        res_status_in = ppsl_pkg::ST_EMPTY;
                        state_in      = ppsl_pkg::S_EMIT;
                     end else if (stage_ovf_ff) begin
                        res_status_in = ppsl_pkg::ST_OVF;
                        state_in      = ppsl_pkg::S_EMIT;
                     end else begin
                        state_in = ppsl_pkg::S_RKEY;
                     end
                  end
                  ppsl_pkg::OP_QUERY: begin
                     res_kind_in   = ppsl_pkg::KIND_QUERY;
                     res_status_in = ppsl_pkg::ST_OK;
                     neg_in        = (in_time < act_t0_ff);
                     qdiff_in      = (in_time < act_t0_ff) ? act_t0_ff - in_time
                                                           : in_time - act_t0_ff;
                     if (act_count_ff == '0) begin
                        res_found_in = 1'b0;
                        res_phase_in = '0;
                        state_in     = ppsl_pkg::S_EMIT;
                     end else if (act_count_ff == CW'(1) || cycle_ff == '0) begin
                        res_found_in = 1'b1;
                        res_phase_in = act_p0_ff;
                        state_in     = ppsl_pkg::S_EMIT;
                     end else begin
                        res_found_in = 1'b1;
                        state_in     = ppsl_pkg::S_QSTART;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // rank sort: position of entry i = entries ahead of it
         ppsl_pkg::S_RKEY: begin
            st_raddr = i_ff[AW-1:0];
            state_in = ppsl_pkg::S_GKEY;
         end
         ppsl_pkg::S_GKEY: begin
            key_t_in = st_t;
            key_p_in = st_p;
            j_in     = '0;
            rank_in  = '0;
            state_in = ppsl_pkg::S_RJ;
         end
         ppsl_pkg::S_RJ: begin
            st_raddr = j_ff[AW-1:0];
            state_in = ppsl_pkg::S_EJ;
         end
         ppsl_pkg::S_EJ: begin
            if (st_t < key_t_ff || (st_t == key_t_ff && st_p < key_p_ff) ||
                (st_t == key_t_ff && st_p == key_p_ff && j_ff < i_ff)) begin
               rank_in = rank_ff + AW'(1);
            end
            j_in = j_ff + CW'(1);
            if (j_ff + CW'(1) == n_ff) begin
               state_in = ppsl_pkg::S_WR;
            end else begin
               state_in = ppsl_pkg::S_RJ;
            end
         end
         ppsl_pkg::S_WR: begin
            ac_we = 1'b1;
            i_in  = i_ff + CW'(1);
            if (i_ff + CW'(1) == n_ff) begin
               i_in     = '0;
               state_in = ppsl_pkg::S_TRD;
            end else begin
               state_in = ppsl_pkg::S_RKEY;
            end
         end

         // trim to one period over the sorted bank
         ppsl_pkg::S_TRD: begin
            ac_raddr = {~bank_ff, i_ff[AW-1:0]};
            state_in = ppsl_pkg::S_TEV;
         end
         ppsl_pkg::S_TEV: begin
            prev_t_in = ac_t;
            prev_p_in = ac_p;
            state_in  = ppsl_pkg::S_TRD;
            i_in      = i_ff + CW'(1);
            if (i_ff == '0) begin
               t0_in = ac_t;
               p0_in = ac_p;
               if (n_ff == CW'(1)) begin
                  last_in   = '0;
                  last_t_in = ac_t;
                  last_p_in = ac_p;
                  state_in  = ppsl_pkg::S_CHK;
               end
            end else if (i_ff == CW'(1)) begin
               p1_in = ac_p;
               if (n_ff == CW'(2)) begin
                  last_in   = i_ff;
                  last_t_in = ac_t;
                  last_p_in = ac_p;
                  state_in  = ppsl_pkg::S_CHK;
               end
            end else if (i_ff >= CW'(3) && ac_p == p1_ff) begin
               last_in   = i_ff - CW'(1);
               last_t_in = prev_t_ff;
               last_p_in = prev_p_ff;
               state_in  = ppsl_pkg::S_CHK;
            end else if (i_ff + CW'(1) == n_ff || ac_p == p0_ff) begin
               last_in   = i_ff;
               last_t_in = ac_t;
               last_p_in = ac_p;
               state_in  = ppsl_pkg::S_CHK;
            end
         end
         ppsl_pkg::S_CHK: begin
            state_in = ppsl_pkg::S_EMIT;
            if (last_p_ff != p0_ff) begin
               res_status_in = ppsl_pkg::ST_NOREP;
            end else if (last_ff != '0 && last_t_ff == t0_ff) begin
               res_status_in = ppsl_pkg::ST_ZERO;
            end else begin
               res_status_in = ppsl_pkg::ST_OK;
               bank_in       = ~bank_ff;
               act_count_in  = last_ff + CW'(1);
               cycle_in      = last_t_ff - t0_ff;
               act_t0_in     = t0_ff;
               act_p0_in     = p0_ff;
            end
         end

         // query: offset into the period, then first entry at or past it
         ppsl_pkg::S_QSTART: begin
            mod_start = 1'b1;
            state_in  = ppsl_pkg::S_QMOD;
         end
         ppsl_pkg::S_QMOD: begin
            if (mod_done) begin
               off_in   = (neg_ff && mod_rem != '0) ? cycle_ff - mod_rem : mod_rem;
               i_in     = '0;
               state_in = ppsl_pkg::S_QRD;
            end
         end
         ppsl_pkg::S_QRD: begin
            ac_raddr = {bank_ff, i_ff[AW-1:0]};
            state_in = ppsl_pkg::S_QEV;
         end
         ppsl_pkg::S_QEV: begin
            i_in = i_ff + CW'(1);
            if ((ac_t - act_t0_ff) >= off_ff || i_ff + CW'(1) == act_count_ff) begin
               res_phase_in = ac_p;
               state_in     = ppsl_pkg::S_EMIT;
            end else begin
               state_in = ppsl_pkg::S_QRD;
            end
         end

         ppsl_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_data_in  = {res_phase_ff, res_found_ff, res_status_ff};
               state_in     = ppsl_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ppsl_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ppsl_pkg::S_IDLE;
         stage_count_ff <= '0;
         stage_ovf_ff   <= 1'b0;
         act_count_ff   <= '0;
         cycle_ff       <= '0;
         bank_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stage_count_ff <= stage_count_in;
         stage_ovf_ff   <= stage_ovf_in;
         act_count_ff   <= act_count_in;
         cycle_ff       <= cycle_in;
         bank_ff        <= bank_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      act_t0_ff     <= act_t0_in;
      act_p0_ff     <= act_p0_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      rank_ff       <= rank_in;
      key_t_ff      <= key_t_in;
      key_p_ff      <= key_p_in;
      t0_ff         <= t0_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      prev_t_ff     <= prev_t_in;
      prev_p_ff     <= prev_p_in;
      last_t_ff     <= last_t_in;
      last_p_ff     <= last_p_in;
      last_ff       <= last_in;
      qdiff_ff      <= qdiff_in;
      neg_ff        <= neg_in;
      off_ff        <= off_in;
      res_kind_ff   <= res_kind_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_phase_ff  <= res_phase_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
`default_nettype wire

[rtl/core/ppsl_ram.sv]
`default_nettype none
module ppsl_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/ppsl_mod.sv]
`default_nettype none
// Restoring remainder, one dividend bit per cycle.
module ppsl_mod #(
   parameter int TIME_WIDTH = ppsl_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [TIME_WIDTH-1:0] dividend,
   input  wire logic [TIME_WIDTH-1:0] divisor,
   output logic                       done,
   output logic      [TIME_WIDTH-1:0] remainder
);

   localparam int NW = $clog2(TIME_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [NW-1:0]         cnt_ff, cnt_in;
   logic [TIME_WIDTH-1:0] dvd_ff, dvd_in;
   logic [TIME_WIDTH-1:0] rem_ff, rem_in;
   logic [TIME_WIDTH:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[TIME_WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[TIME_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = TIME_WIDTH'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[TIME_WIDTH-1:0];
         end
         cnt_in = cnt_ff + NW'(1);
         if (cnt_ff == NW'(TIME_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

[rtl/core/ppsl_checker.sv]
`default_nettype none
module ppsl_checker #(
   parameter int TIME_WIDTH = ppsl_pkg::TIME_WIDTH_DEF
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [((TIME_WIDTH+ppsl_pkg::PHASE_W+7)/8)*8-1:0] req_tdata,
   input wire logic [1:0]                          req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [7:0]                          rsp_tdata,
   input wire logic [0:0]                          rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_commit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == ppsl_pkg::KIND_COMMIT |->
         rsp_tdata[7:3] == 5'd0 && rsp_tdata[2:0] <= ppsl_pkg::ST_ZERO)
      else $error("bad commit result");

   a_query_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == ppsl_pkg::KIND_QUERY |->
         rsp_tdata[2:0] == ppsl_pkg::ST_OK && (rsp_tdata[3] || rsp_tdata[7:4] == 4'd0))
      else $error("bad query result");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ppsl_pkg::OP_LOAD |=> !$rose(rsp_tvalid))
      else $error("load produced a result");

   a_busy_after_query: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ppsl_pkg::OP_QUERY && req_tdata[0] == 1'b0
         |=> !req_tready)
      else $error("query not taken");

endmodule

bind periodic_phase_schedule_lookup_unit ppsl_checker #(.TIME_WIDTH(TIME_WIDTH)) u_ppsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[verif/periodic_phase_schedule_lookup_unit_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module periodic_phase_schedule_lookup_unit_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic [1:0] req_tuser,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,
   input  wire logic [0:0] rsp_tuser,
   output int              fail_count,
   output int              pending_count,
   output int              commit_seen,
   output int              query_seen
);
   localparam int DEPTH = 16;

   typedef struct packed {
      logic       kind;
      logic [2:0] status;
      logic       found;
      logic [3:0] phase;
   } sched_result_type;

   logic [47:0] stg_time [DEPTH];
   logic [3:0]  stg_phase [DEPTH];
   int          stg_count;
   bit          stg_ovf;
   logic [47:0] act_time [DEPTH];
   logic [3:0]  act_phase [DEPTH];
   int          act_count;
   logic [47:0] cyc_len;

   sched_result_type expected_q[$];

   function automatic logic [2:0] commit_schedule();
      logic [47:0] t [DEPTH];
      logic [3:0]  p [DEPTH];
      logic [47:0] kt;
      logic [3:0]  kp;
      int n, i, j, k;
      n = stg_count;
      if (n == 0) return ppsl_pkg::ST_EMPTY;
      if (stg_ovf) return ppsl_pkg::ST_OVF;
      for (i = 0; i < DEPTH; i++) begin
         t[i] = stg_time[i];
         p[i] = stg_phase[i];
      end
      // insertion sort by time, then phase
      for (i = 1; i < n; i++) begin
         kt = t[i];
         kp = p[i];
         j = i;
         while (j > 0 && (kt < t[j-1] || (kt == t[j-1] && kp < p[j-1]))) begin
            t[j] = t[j-1];
            p[j] = p[j-1];
            j--;
         end
         t[j] = kt;
         p[j] = kp;
      end
      // trim to one cycle
      if (n > 2) begin
         k = 2;
         while (k + 1 < n && p[k] != p[0] && p[k+1] != p[1]) k++;
         n = k + 1;
      end
      if (p[n-1] != p[0]) return ppsl_pkg::ST_NOREP;
      if (n > 1 && t[n-1] == t[0]) return ppsl_pkg::ST_ZERO;
      for (i = 0; i < DEPTH; i++) begin
         act_time[i]  = t[i];
         act_phase[i] = p[i];
      end
      act_count = n;
      cyc_len = t[n-1] - t[0];
      return ppsl_pkg::ST_OK;
   endfunction

   function automatic logic [3:0] phase_at(logic [47:0] q);
      logic [47:0] t0, r, off;
      int i;
      t0 = act_time[0];
      if (act_count == 1 || cyc_len == 0) return act_phase[0];
      if (q >= t0) off = (q - t0) % cyc_len;
      else begin
         r = (t0 - q) % cyc_len;
         off = (r == 0) ? 48'd0 : cyc_len - r;
      end
      for (i = 0; i < act_count; i++)
         if (act_time[i] - t0 >= off) return act_phase[i];
      return act_phase[act_count-1];
   endfunction

   always @(posedge clock) begin
      sched_result_type res, got;
      if (reset) begin
         stg_count = 0;
         stg_ovf   = 0;
         act_count = 0;
         cyc_len   = '0;
         fail_count <= 0;
         commit_seen <= 0;
         query_seen <= 0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[2:0], rsp_tdata[3], rsp_tdata[7:4]};
            if (got.kind == ppsl_pkg::KIND_COMMIT) commit_seen <= commit_seen + 1;
            else query_seen <= query_seen + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               res = expected_q.pop_front();
               if (res !== got) begin
                  $display("%0t: mismatch expected kind %0d st %0d found %0d ph %0d,",
                           $time, res.kind, res.status, res.found, res.phase);
                  $display("   actual kind %0d st %0d found %0d ph %0d",
                           got.kind, got.status, got.found, got.phase);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ppsl_pkg::OP_LOAD: begin
                  if (stg_count < DEPTH) begin
                     stg_time[stg_count]  = req_tdata[47:0];
                     stg_phase[stg_count] = req_tdata[51:48];
                     stg_count = stg_count + 1;
                  end else stg_ovf = 1;
               end
               ppsl_pkg::OP_COMMIT: begin
                  res = '0;
                  res.kind = ppsl_pkg::KIND_COMMIT;
                  res.status = commit_schedule();
                  stg_count = 0;
                  stg_ovf = 0;
                  expected_q.push_back(res);
               end
               ppsl_pkg::OP_QUERY: begin
                  res = '0;
                  res.kind = ppsl_pkg::KIND_QUERY;
                  if (act_count != 0) begin
                     res.found = 1;
                     res.phase = phase_at(req_tdata[47:0]);
                  end
                  expected_q.push_back(res);
               end
               default: ;
            endcase
         end
      end
   end

   assign pending_count = expected_q.size();
endmodule
`default_nettype wire

[verif/periodic_phase_schedule_lookup_unit_test.sv]
`timescale 1ns / 100ps
`default_nettype none
// Stimulus and verdict for the phase schedule unit. The checker beside the
// block follows every transaction and counts failures; this module only
// drives loads, commits, queries and spare ops, and applies back-pressure.
module periodic_phase_schedule_lookup_unit_test;

   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = ppsl_pkg::OP_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;

   int fail_count, pending_count, commit_seen, query_seen;
   int send_idle_pct = 24;  // sender gap rate, percent
   int recv_idle_pct = 52;  // receiver stall rate, percent
   bit hold_off = 0;         // long receiver stall request
   longint cycles = 0;
   int ops_sent = 0;

   always #6 clock = ~clock;

   periodic_phase_schedule_lookup_unit i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   periodic_phase_schedule_lookup_unit_checker i_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending_count, .commit_seen, .query_seen
   );

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stalls, plus a long counted hold-off on request
   always @(posedge clock) begin
      int n;
      if (reset) rsp_tready <= 0;
      else if (hold_off) begin
         rsp_tready <= 0;
         for (n = 0; n < 1500; n++) @(posedge clock);
         hold_off = 0;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one transaction; gaps inserted before it
   task automatic send(logic [1:0] op, logic [47:0] t, logic [3:0] ph);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, ph, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ops_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [47:0] rnd_time();
      case ($urandom_range(3))
         0: return 48'({$urandom, $urandom});
         1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(50));
         default: return 48'($urandom_range(400));
      endcase
   endfunction

   function automatic logic [3:0] rnd_phase();
      return 4'($urandom_range(15));
   endfunction

   // well-formed schedule: phases rotate and close on the first one
   task automatic load_cycle(int plen, logic [47:0] base, int span);
      logic [3:0] ph [8];
      logic [47:0] t;
      int i;
      for (i = 0; i < plen; i++) ph[i] = 4'($urandom_range(9));
      t = base;
      for (i = 0; i <= plen; i++) begin
         send(ppsl_pkg::OP_LOAD, t, ph[i % plen]);
         t = t + 48'($urandom_range(1, span));
      end
   endtask

   task automatic random_phase(int items);
      int k;
      k = 0;
      while (k < items) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               load_cycle(int'($urandom_range(2, 5)), rnd_time(),
                          int'($urandom_range(1, 1000)));
               send(ppsl_pkg::OP_COMMIT, rnd_time(), rnd_phase());
               k += 6;
            end
            4: begin
               repeat ($urandom_range(1, 18))
                  send(ppsl_pkg::OP_LOAD,
                       ($urandom_range(1) ? rnd_time() : 48'($urandom_range(20))),
                       rnd_phase());
               send(ppsl_pkg::OP_COMMIT, rnd_time(), rnd_phase());
               k += 8;
            end
            5: begin
               send(ppsl_pkg::OP_COMMIT, rnd_time(), rnd_phase());
               k++;
            end
            6: begin
               send(ppsl_pkg::OP_SPARE, rnd_time(), rnd_phase()); // ignored op
            end
            default: begin
               send(ppsl_pkg::OP_QUERY, rnd_time(), rnd_phase());
               k++;
            end
         endcase
      end
   endtask

   initial begin
      int i;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: query and commit with nothing loaded
      send(ppsl_pkg::OP_QUERY, 48'h0, 4'd0);
      send(ppsl_pkg::OP_COMMIT, 48'h0, 4'd0);
      // single entry schedule, extreme times
      send(ppsl_pkg::OP_LOAD, 48'hFFFF_FFFF_FFFF, 4'd15);
      send(ppsl_pkg::OP_COMMIT, 48'h0, 4'd0);
      send(ppsl_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 4'd15);
      send(ppsl_pkg::OP_QUERY, 48'h0, 4'd0);
      // zero cycle: same time, same phase
      send(ppsl_pkg::OP_LOAD, 48'd5, 4'd3);
      send(ppsl_pkg::OP_LOAD, 48'd5, 4'd3);
      send(ppsl_pkg::OP_COMMIT, 48'd0, 4'd0);
      // no repeated phase
      send(ppsl_pkg::OP_LOAD, 48'd1, 4'd1);
      send(ppsl_pkg::OP_LOAD, 48'd9, 4'd2);
      send(ppsl_pkg::OP_COMMIT, 48'd0, 4'd0);
      // times near both ends of the time range; the first phase does not repeat
      send(ppsl_pkg::OP_LOAD, 48'hFFFF_FFFF_FFF0, 4'd9);
      send(ppsl_pkg::OP_LOAD, 48'h10, 4'd4);
      send(ppsl_pkg::OP_LOAD, 48'h8, 4'd0);
      send(ppsl_pkg::OP_COMMIT, 48'd0, 4'd0);
      send(ppsl_pkg::OP_QUERY, 48'h7, 4'd0);
      send(ppsl_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 4'd0);
      // overflow: seventeen loads
      for (i = 0; i < 17; i++) send(ppsl_pkg::OP_LOAD, 48'(i), 4'(i % 10));
      send(ppsl_pkg::OP_COMMIT, 48'd0, 4'd0);
      send(ppsl_pkg::OP_QUERY, 48'd3, 4'd0);
      drain();

      random_phase(600);
      drain();
      send_idle_pct = 52;
      recv_idle_pct = 24;
      // long receiver stall while items keep coming
      hold_off = 1;
      random_phase(60);
      drain();
      random_phase(540);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(600);
      drain();

      repeat (200) @(posedge clock);
      $display("Run covered %0d input transactions, %0d commit and %0d query results.",
               ops_sent, commit_seen, query_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
